### rtl/core/spfla_pkg.sv
// shared types and constants for the slot pool free list allocator
`default_nettype none

package spfla_pkg;

    localparam int POOL_SLOTS_DEF = 2048;
    localparam int SLOT_FIELD_W   = 11;
    localparam int STATUS_W       = 2;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_BAD_FREE  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic accept;
        logic commit;
    } t_ctrl_cmd;

endpackage

`default_nettype wire

### rtl/core/spfla_ctrl.sv
// request sequencer and output valid tracking for the allocator
`default_nettype none

module spfla_ctrl
    import spfla_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_req_valid,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    input  wire logic      i_rsp_ready,
    output t_ctrl_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                // result register must be free or draining this cycle
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.commit | (r_out_valid & ~i_rsp_ready);
    end

    assign o_rsp_valid = r_out_valid;

endmodule

`default_nettype wire

### rtl/core/spfla_dp.sv
// free list head, bump counter, link and live stores, result register
`default_nettype none

module spfla_dp
    import spfla_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_ctrl_cmd               i_cmd,
    input  wire t_func                   i_func,
    input  wire logic [SLOT_FIELD_W-1:0] i_slot,
    output logic [SLOT_FIELD_W-1:0]      o_slot_granted,
    output t_status                      o_status,
    output logic                         o_from_free_list
);

    localparam int SLOT_W = $clog2(POOL_SLOTS);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int CMP_W  = (CNT_W > SLOT_FIELD_W) ? CNT_W : SLOT_FIELD_W;
    localparam logic [CNT_W-1:0] POOL_LIMIT = CNT_W'(POOL_SLOTS);

    logic [SLOT_W-1:0] mem_link [POOL_SLOTS];
    logic              mem_live [POOL_SLOTS];

    logic [SLOT_W-1:0]       r_free_head;
    logic [SLOT_W-1:0]       n_free_head;
    logic [CNT_W-1:0]        r_bump_next;
    logic [CNT_W-1:0]        n_bump_next;

    t_func                   r_func;
    logic [CMP_W-1:0]        r_slot;
    logic [SLOT_W-1:0]       r_link_rd;
    logic                    r_live_rd;

    logic [SLOT_FIELD_W-1:0] r_granted;
    t_status                 r_status;
    logic                    r_recycled;

    logic [CMP_W-1:0]        req_slot;
    logic [SLOT_W-1:0]       slot_addr;
    logic [SLOT_W-1:0]       granted;
    logic [CMP_W-1:0]        granted_ext;
    t_status                 status;
    logic                    recycled;
    logic                    free_ok;
    logic                    link_we;
    logic                    live_we;
    logic                    live_wdata;
    logic [SLOT_W-1:0]       live_waddr;

    assign req_slot  = CMP_W'(i_slot);
    assign slot_addr = r_slot[SLOT_W-1:0];

    // request capture and store reads; the read data is registered for the commit state
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func    <= i_func;
            r_slot    <= req_slot;
            r_link_rd <= mem_link[r_free_head];
            r_live_rd <= mem_live[req_slot[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            mem_link[slot_addr] <= r_free_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (live_we) begin
            mem_live[live_waddr] <= live_wdata;
        end
    end

    // live bits below the bump counter have all been written by a grant
    assign free_ok = (r_slot != '0) && (r_slot < CMP_W'(r_bump_next)) && r_live_rd;

    always_comb begin
        n_free_head = r_free_head;
        n_bump_next = r_bump_next;
        granted     = '0;
        status      = ST_OK;
        recycled    = 1'b0;
        link_we     = 1'b0;
        live_we     = 1'b0;
        live_wdata  = 1'b0;
        live_waddr  = slot_addr;
        unique case (r_func)
            FUNC_ALLOC: begin
                priority if (r_free_head != '0) begin
                    granted     = r_free_head;
                    n_free_head = r_link_rd;
                    recycled    = 1'b1;
                    live_we     = i_cmd.commit;
                    live_wdata  = 1'b1;
                    live_waddr  = r_free_head;
                end else if (r_bump_next < POOL_LIMIT) begin
                    granted     = r_bump_next[SLOT_W-1:0];
                    n_bump_next = r_bump_next + 1'b1;
                    live_we     = i_cmd.commit;
                    live_wdata  = 1'b1;
                    live_waddr  = r_bump_next[SLOT_W-1:0];
                end else begin
                    status = ST_EXHAUSTED;
                end
            end
            FUNC_FREE: begin
                if (free_ok) begin
                    n_free_head = slot_addr;
                    link_we     = i_cmd.commit;
                    live_we     = i_cmd.commit;
                    live_wdata  = 1'b0;
                end else begin
                    status = ST_BAD_FREE;
                end
            end
            default: status = ST_BAD_FREE;
        endcase
    end

    assign granted_ext = CMP_W'(granted);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_bump_next <= CNT_W'(1);
        end else if (i_cmd.commit) begin
            r_free_head <= n_free_head;
            r_bump_next <= n_bump_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_granted  <= granted_ext[SLOT_FIELD_W-1:0];
            r_status   <= status;
            r_recycled <= recycled;
        end
    end

    assign o_slot_granted   = r_granted;
    assign o_status         = r_status;
    assign o_from_free_list = r_recycled;

endmodule

`default_nettype wire

### rtl/core/slot_pool_free_list_allocator_unit.sv
// top level of the slot pool free list allocator
`default_nettype none

// Hands out slots 1 to POOL_SLOTS-1 (slot 0 is the null value). An
// allocate transfer pops the free list head, or failing that takes the
// next never-used slot from a bump counter; a free transfer pushes the
// slot back. Each request gives exactly one result transfer carrying the
// slot granted, a status (ok, pool exhausted, invalid or double free) and
// a flag for a recycled slot. The idle state accepts a request and
// registers the read of the next-link and live stores, and the execute
// state commits the update and loads the result register. A new request
// is taken while the previous result waits on the output side; a request
// stalls in the execute state only while an untaken result still
// occupies the output. No clearing pass is needed after reset.
module slot_pool_free_list_allocator_unit
    import spfla_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // [10:0] slot_to_free, [15:11] zero
    input  wire logic        i_s_axis_tuser,   // [0] func
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [10:0] slot_granted, [12:11] status, [15:13] zero
    output logic             o_m_axis_tuser    // [0] from_free_list
);

    t_ctrl_cmd               cmd;
    logic [SLOT_FIELD_W-1:0] slot_granted;
    t_status                 status;
    logic                    from_free_list;

    spfla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .o_rsp_valid (o_m_axis_tvalid),
        .i_rsp_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    spfla_dp #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_func           (t_func'(i_s_axis_tuser)),
        .i_slot           (i_s_axis_tdata[SLOT_FIELD_W-1:0]),
        .o_slot_granted   (slot_granted),
        .o_status         (status),
        .o_from_free_list (from_free_list)
    );

    assign o_m_axis_tdata = {3'b000, status, slot_granted};
    assign o_m_axis_tuser = from_free_list;

endmodule

`default_nettype wire

### tb/slot_pool_checker.sv
// scoreboard that predicts every slot pool reply and checks it against the output transfers
`default_nettype none

module slot_pool_checker
    import spfla_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_tvalid,
    input  wire logic        i_req_tready,
    input  wire logic [15:0] i_req_tdata,   // [10:0] slot_to_free, [15:11] zero
    input  wire logic        i_req_tuser,   // [0] func
    input  wire logic        i_rsp_tvalid,
    input  wire logic        i_rsp_tready,
    input  wire logic [15:0] i_rsp_tdata,   // [10:0] slot_granted, [12:11] status, [15:13] zero
    input  wire logic        i_rsp_tuser,   // [0] from_free_list
    output int               o_mismatches,
    output int               o_outstanding,
    output int               o_checked
);

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        t_status                 status;
        logic                    recycled;
    } t_slot_reply;

    // shadow copy of the allocator state
    logic [SLOT_FIELD_W-1:0] head_slot;
    logic [SLOT_FIELD_W:0]   bump_slot;
    logic [SLOT_FIELD_W-1:0] link_mem [POOL_SLOTS];
    bit                      live_bits [POOL_SLOTS];

    t_slot_reply             due_replies [$];
    int                      mismatches;
    int                      checked;

    function automatic t_slot_reply serve_request(t_func op, logic [SLOT_FIELD_W-1:0] slot);
        t_slot_reply reply;
        reply = '0;
        reply.status = ST_OK;
        if (op == FUNC_ALLOC) begin
            if (head_slot != 0) begin
                reply.slot = head_slot;
                reply.recycled = 1'b1;
                head_slot = link_mem[reply.slot];
                live_bits[reply.slot] = 1'b1;
            end else if (bump_slot < POOL_SLOTS) begin
                reply.slot = bump_slot[SLOT_FIELD_W-1:0];
                bump_slot = bump_slot + 1'b1;
                live_bits[reply.slot] = 1'b1;
            end else begin
                reply.status = ST_EXHAUSTED;
            end
        end else if (slot != 0 && slot < bump_slot && live_bits[slot]) begin
            // push onto the free list
            link_mem[slot] = head_slot;
            head_slot = slot;
            live_bits[slot] = 1'b0;
        end else begin
            reply.status = ST_BAD_FREE;
        end
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_slot_reply want;
        t_slot_reply got;
        if (!i_rst_n) begin
            head_slot = '0;
            bump_slot = 1;
            foreach (live_bits[i]) live_bits[i] = 1'b0;
            due_replies.delete();
        end else begin
            if (i_rsp_tvalid && i_rsp_tready) begin
                got.slot = i_rsp_tdata[SLOT_FIELD_W-1:0];
                got.status = t_status'(i_rsp_tdata[SLOT_FIELD_W+STATUS_W-1:SLOT_FIELD_W]);
                got.recycled = i_rsp_tuser;
                checked++;
                if (due_replies.size() == 0) begin
                    mismatches++;
                    $display("%0t slot_pool_checker: expected no transfer, got slot %0d status %0d",
                             $time, got.slot, got.status);
                end else begin
                    want = due_replies.pop_front();
                    if (got.slot !== want.slot) begin
                        mismatches++;
                        $display("%0t slot_pool_checker: slot_granted expected %0d got %0d",
                                 $time, want.slot, got.slot);
                    end
                    if (got.status !== want.status) begin
                        mismatches++;
                        $display("%0t slot_pool_checker: status expected %0d got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.recycled !== want.recycled) begin
                        mismatches++;
                        $display("%0t slot_pool_checker: from_free_list expected %0d got %0d",
                                 $time, want.recycled, got.recycled);
                    end
                end
            end
            if (i_req_tvalid && i_req_tready) begin
                due_replies.push_back(serve_request(t_func'(i_req_tuser),
                                                    i_req_tdata[SLOT_FIELD_W-1:0]));
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= due_replies.size();
        o_checked     <= checked;
    end

endmodule

`default_nettype wire

### tb/tb_top.sv
// top of the allocator testbench: clock, reset, request and reply traffic, verdict
`default_nettype none

module tb_top;
    import spfla_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int IDLE_PCT        = 7;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    req_valid = 1'b0;
    logic                    req_ready;
    logic [15:0]             req_data  = '0;
    logic                    req_user  = FUNC_ALLOC;
    logic                    rsp_valid;
    logic                    rsp_ready = 1'b0;
    logic [15:0]             rsp_data;
    logic                    rsp_user;

    logic                    steady    = 1'b0;
    logic                    hold_req  = 1'b0;
    logic                    hold_done = 1'b0;
    int                      hold_left = 0;

    int                      mismatches;
    int                      outstanding;
    int                      checked;

    // slots seen granted and not yet sent back, used to build well-formed frees
    logic [SLOT_FIELD_W-1:0] granted_q [$];
    logic [SLOT_FIELD_W-1:0] last_freed = '0;
    int                      sent = 0;
    int                      exhausted_seen = 0;
    int                      rejected_seen = 0;
    int                      recycled_seen = 0;

    always #10 clk = ~clk;

    slot_pool_free_list_allocator_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .i_s_axis_tuser  (req_user),
        .o_m_axis_tvalid (rsp_valid),
        .i_m_axis_tready (rsp_ready),
        .o_m_axis_tdata  (rsp_data),
        .o_m_axis_tuser  (rsp_user)
    );

    slot_pool_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_tvalid  (req_valid),
        .i_req_tready  (req_ready),
        .i_req_tdata   (req_data),
        .i_req_tuser   (req_user),
        .i_rsp_tvalid  (rsp_valid),
        .i_rsp_tready  (rsp_ready),
        .i_rsp_tdata   (rsp_data),
        .i_rsp_tuser   (rsp_user),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    // reply side: random stalls, one long hold-off on request
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_OFF_CYCLES;
            hold_done <= 1'b1;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // sampled mid-cycle so the request side sees it without a race
    always @(negedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) begin
            if (rsp_data[SLOT_FIELD_W-1:0] != 0)
                granted_q.push_back(rsp_data[SLOT_FIELD_W-1:0]);
            case (t_status'(rsp_data[SLOT_FIELD_W+STATUS_W-1:SLOT_FIELD_W]))
                ST_EXHAUSTED: exhausted_seen++;
                ST_BAD_FREE:  rejected_seen++;
                default: ;
            endcase
            if (rsp_user)
                recycled_seen++;
        end
    end

    task automatic send_request(input t_func op, input logic [SLOT_FIELD_W-1:0] slot);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_user  <= op;
        req_data  <= {{(16-SLOT_FIELD_W){1'b0}}, slot};
        do @(posedge clk); while (!req_ready);
        sent++;
    endtask

    // mix of allocates, frees of granted slots and malformed frees
    task automatic send_random(input int alloc_pct, input int free_pct);
        int                      pick;
        int                      idx;
        logic [SLOT_FIELD_W-1:0] slot;
        pick = $urandom_range(99);
        if (pick < alloc_pct) begin
            send_request(FUNC_ALLOC, SLOT_FIELD_W'($urandom));
        end else if (pick < alloc_pct + free_pct && granted_q.size() != 0) begin
            idx = $urandom_range(granted_q.size() - 1);
            slot = granted_q[idx];
            granted_q.delete(idx);
            last_freed = slot;
            send_request(FUNC_FREE, slot);
        end else begin
            case ($urandom_range(3))
                0: slot = '0;
                1: slot = SLOT_FIELD_W'($urandom);
                2: slot = last_freed;
                default: slot = '1;
            endcase
            send_request(FUNC_FREE, slot);
        end
    endtask

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        int grow_items;
        grow_items = 0;
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // null, never-issued and top-of-range frees on an empty pool
        send_request(FUNC_FREE, '0);
        send_request(FUNC_FREE, 11'd5);
        send_request(FUNC_FREE, '1);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, '1);
        send_request(FUNC_ALLOC, 11'd1234);
        // free, double free, recycle
        send_request(FUNC_FREE, 11'd2);
        send_request(FUNC_FREE, 11'd2);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_FREE, 11'd1);
        send_request(FUNC_FREE, 11'd3);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_FREE, 11'd4);
        send_request(FUNC_FREE, 11'd4);
        send_request(FUNC_FREE, 11'd6);
        send_request(FUNC_FREE, 11'd5);
        send_request(FUNC_ALLOC, '1);
        send_request(FUNC_ALLOC, '0);

        // let the pipeline empty before the random traffic
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);

        // churn while few slots of the pool are in use
        repeat (30) send_random(50, 40);

        // fill the pool until it runs dry, first stretch without any idling
        steady <= 1'b1;
        while (exhausted_seen < 12) begin
            if (grow_items == 600)
                steady <= 1'b0;
            send_random(100, 0);
            grow_items++;
        end

        // churn on a full pool while the reply side holds off for a while
        hold_req <= 1'b1;
        repeat (50) send_random(48, 44);

        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_top: %0d requests sent, %0d replies checked, %0d recycled grants",
                 sent, checked, recycled_seen);
        $display("tb_top: %0d exhausted allocates and %0d rejected frees over the run",
                 exhausted_seen, rejected_seen);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
